@@ rtl/ir_pulse_width_byte_decoder_core_macros.svh @@
// Assertion macros used by the IR pulse width decoder assertion checker.
`ifndef IR_PULSE_WIDTH_BYTE_DECODER_CORE_MACROS_SVH
`define IR_PULSE_WIDTH_BYTE_DECODER_CORE_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define IRPWD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define IRPWD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/irpwd_pkg.sv @@
// Shared types and constants of the IR pulse width byte decoder.
`default_nettype none

package irpwd_pkg;

  localparam int SAMPLES_PER_ITEM_DEF = 8;
  localparam int COUNTER_BITS_DEF     = 16;

  // Configuration registers are 16 bits wide and addressed by a 2-bit index.
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESYNC_HIGH = 2'd0,
    CFG_HEADER_LOW  = 2'd1,
    CFG_ONE_BIT_LOW = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // latch a new sample beat and clear the per-beat flags
    logic step;  // decode one line sample
    logic emit;  // move the per-beat result into the output register
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic last_step;  // the current step is the final one for this beat
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/irpwd_ctrl.sv @@
// Controller state machine: sequences accept, sample stepping and result hand-off.
`default_nettype none

module irpwd_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output irpwd_pkg::dp_cmd_t    cmd,
  input  irpwd_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a new result when empty or being drained now.
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last_step) begin
          if (out_free) begin
            cmd.emit      = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/irpwd_dpath.sv @@
// Datapath: configuration registers, per-sample decoder state and the output register.
`default_nettype none

module irpwd_dpath #(
  parameter int SAMPLES_PER_ITEM = irpwd_pkg::SAMPLES_PER_ITEM_DEF,
  parameter int COUNTER_BITS     = irpwd_pkg::COUNTER_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [irpwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [irpwd_pkg::REG_W-1:0]      cfg_wdata,
  input  wire [SAMPLES_PER_ITEM-1:0]      samples,
  input  irpwd_pkg::dp_cmd_t              cmd,
  output irpwd_pkg::dp_status_t           status,
  output logic [irpwd_pkg::DATA_W-1:0]    data_byte,
  output logic                            byte_ready,
  output logic                            frame_error
);

  localparam int IDX_W  = (SAMPLES_PER_ITEM > 1) ? $clog2(SAMPLES_PER_ITEM) : 1;
  localparam int CW     = COUNTER_BITS;
  localparam int CMPW   = (CW > irpwd_pkg::REG_W) ? CW : irpwd_pkg::REG_W;
  localparam int WINDOW = 8;
  localparam logic [2:0] LAST_BIT = 3'd7;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  typedef enum logic [1:0] {
    PH_RESYNC = 2'd0,
    PH_HEADER = 2'd1,
    PH_HIGH   = 2'd2,
    PH_LOW    = 2'd3
  } phase_t;

  logic [irpwd_pkg::REG_W-1:0] resync_r, header_r, one_bit_r;

  phase_t                            phase_r, phase_nxt;
  logic [CW-1:0]                     tick_r, tick_nxt;
  logic [CW-1:0]                     level_r, level_nxt;
  logic [irpwd_pkg::DATA_W-1:0]      shift_r, shift_nxt;
  logic [2:0]                        bitc_r, bitc_nxt;

  logic [SAMPLES_PER_ITEM-1:0]       samp_r;
  logic [IDX_W-1:0]                  idx_r;
  logic                              item_done_r, item_err_r;
  logic [irpwd_pkg::DATA_W-1:0]      item_byte_r;

  logic s;
  logic step_done, step_err;

  assign s                = samp_r[SAMPLES_PER_ITEM-1];
  assign status.last_step = step_err || (idx_r == IDX_W'(SAMPLES_PER_ITEM - 1));

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // One sample of the decoder.
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = sat_inc(tick_r);
    level_nxt = level_r;
    shift_nxt = shift_r;
    bitc_nxt  = bitc_r;
    step_done = 1'b0;
    step_err  = 1'b0;
    case (phase_r)
      PH_RESYNC: begin
        if (!s) begin
          tick_nxt  = '0;
          level_nxt = '0;
          shift_nxt = '0;
          bitc_nxt  = '0;
        end else if (CMPW'(tick_nxt) > CMPW'(resync_r)) begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (!s) begin
          level_nxt = sat_inc(level_r);
          if (CMPW'(level_nxt) >= CMPW'(header_r)) begin
            phase_nxt = PH_HIGH;
            tick_nxt  = '0;
            level_nxt = '0;
          end
        end
      end
      PH_HIGH: begin
        if (s) begin
          if (level_r == '0) begin
            tick_nxt = CW'(1);
          end
          level_nxt = sat_inc(level_r);
        end
        if (tick_nxt >= CW'(WINDOW)) begin
          phase_nxt = PH_LOW;
          tick_nxt  = '0;
          level_nxt = '0;
        end
      end
      PH_LOW: begin
        if (!s) begin
          if (level_r == '0) begin
            tick_nxt = CW'(1);
          end
          level_nxt = sat_inc(level_r);
        end
        if (tick_nxt >= CW'(WINDOW) && level_nxt == '0) begin
          // Empty low window: frame error, back to resync.
          phase_nxt = PH_RESYNC;
          tick_nxt  = '0;
          level_nxt = '0;
          shift_nxt = '0;
          bitc_nxt  = '0;
          step_err  = 1'b1;
        end else if (tick_nxt >= CW'(WINDOW) && s) begin
          shift_nxt = {shift_r[irpwd_pkg::DATA_W-2:0],
                       (CMPW'(level_nxt) >= CMPW'(one_bit_r))};
          phase_nxt = PH_HIGH;
          level_nxt = '0;
          tick_nxt  = '0;
          if (bitc_r == LAST_BIT) begin
            bitc_nxt  = '0;
            step_done = 1'b1;
          end else begin
            bitc_nxt = bitc_r + 3'd1;
          end
        end
      end
      default: begin
        phase_nxt = PH_RESYNC;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resync_r  <= irpwd_pkg::REG_W'(40);
      header_r  <= irpwd_pkg::REG_W'(8);
      one_bit_r <= irpwd_pkg::REG_W'(5);
    end else if (cfg_we) begin
      case (irpwd_pkg::cfg_idx_t'(cfg_index))
        irpwd_pkg::CFG_RESYNC_HIGH: resync_r  <= cfg_wdata;
        irpwd_pkg::CFG_HEADER_LOW:  header_r  <= cfg_wdata;
        irpwd_pkg::CFG_ONE_BIT_LOW: one_bit_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RESYNC;
      tick_r  <= '0;
      level_r <= '0;
      shift_r <= '0;
      bitc_r  <= '0;
    end else if (cmd.step) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      level_r <= level_nxt;
      shift_r <= shift_nxt;
      bitc_r  <= bitc_nxt;
    end
  end

  // Sample shifter, step index and per-beat flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      item_done_r <= 1'b0;
      item_err_r  <= 1'b0;
      item_byte_r <= '0;
    end else if (cmd.load) begin
      idx_r       <= '0;
      item_done_r <= 1'b0;
      item_err_r  <= 1'b0;
      item_byte_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
      if (step_done) begin
        item_done_r <= 1'b1;
        item_byte_r <= shift_nxt;
      end
      if (step_err) begin
        item_err_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp_r <= samples;
    end else if (cmd.step) begin
      samp_r <= samp_r << 1;
    end
  end

  // Output register; the flag and data bits are qualified by the controller's valid.
  // When the result is taken on the final step, that step's own outcome is merged in.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      byte_ready  <= item_done_r || (cmd.step && step_done);
      data_byte   <= (cmd.step && step_done) ? shift_nxt : item_byte_r;
      frame_error <= item_err_r || (cmd.step && step_err);
    end
  end

endmodule

`default_nettype wire

@@ rtl/ir_pulse_width_byte_decoder_core.sv @@
// Top level of the IR pulse width byte decoder: stream ports, controller and datapath.
`default_nettype none

// Decodes a pulse-width IR line from beats of SAMPLES_PER_ITEM oversampled line levels,
// oldest sample in the highest used bit of in_tdata. The decoder waits for a long idle
// high run, counts a low header, then times each data bit as an eight-tick high window
// and a low window; a bit is 1 when its low count reaches one_bit_low_ticks, and eight
// bits make a byte with the first bit in the MSB. Every input beat gives exactly one
// output beat: out_tuser[0] says a byte completed in that beat (out_tdata is zero
// otherwise) and out_tuser[1] flags a low window without any low sample, after which the
// decoder resyncs and drops the rest of that beat's samples. Each beat is accepted in
// the idle state and then stepped one line sample at a time, ending early after a frame
// error; the datapath steps one sample per cycle through a single decode
// stage. A finished result waits in the output register while the next beat is accepted;
// the block holds only when a second result is ready before the first has been taken.
// Configuration writes take effect at once and should be made while no beat is in work.
module ir_pulse_width_byte_decoder_core #(
  parameter int SAMPLES_PER_ITEM = irpwd_pkg::SAMPLES_PER_ITEM_DEF,
  parameter int COUNTER_BITS     = irpwd_pkg::COUNTER_BITS_DEF,
  localparam int IN_TDATA_W      = ((SAMPLES_PER_ITEM + 7) / 8) * 8
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // Configuration write port.
  input  wire                            cfg_we,
  input  wire [irpwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [irpwd_pkg::REG_W-1:0]     cfg_wdata,
  // Input stream.
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire [IN_TDATA_W-1:0]           in_tdata,   // sample_byte
  // Output stream.
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [irpwd_pkg::DATA_W-1:0]   out_tdata,  // data_byte
  output logic [1:0]                     out_tuser   // byte_ready, frame_error
);

  irpwd_pkg::dp_cmd_t    cmd;
  irpwd_pkg::dp_status_t status;
  logic                  byte_ready;
  logic                  frame_error;

  irpwd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  irpwd_dpath #(
    .SAMPLES_PER_ITEM (SAMPLES_PER_ITEM),
    .COUNTER_BITS     (COUNTER_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .samples     (in_tdata[SAMPLES_PER_ITEM-1:0]),
    .cmd         (cmd),
    .status      (status),
    .data_byte   (out_tdata),
    .byte_ready  (byte_ready),
    .frame_error (frame_error)
  );

  assign out_tuser = {frame_error, byte_ready};

endmodule

`default_nettype wire

@@ rtl/irpwd_checker.sv @@
// Port-level assertion checker for the IR pulse width byte decoder, with its bind.
`default_nettype none
`include "ir_pulse_width_byte_decoder_core_macros.svh"

module irpwd_checker #(
  parameter int IN_TDATA_W = 8
) (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_tvalid,
  input wire                          in_tready,
  input wire [IN_TDATA_W-1:0]         in_tdata,
  input wire                          out_tvalid,
  input wire                          out_tready,
  input wire [irpwd_pkg::DATA_W-1:0]  out_tdata,
  input wire [1:0]                    out_tuser
);

  // A result beat stays offered until it is taken.
  `IRPWD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "out beat dropped")

  // Data is zero whenever no byte completed.
  `IRPWD_ASSERT(a_data_zero, clk, rst_n, !(out_tvalid && !out_tuser[0]) || (out_tdata == '0), "data without byte")

  // The accepted beat's samples are stepped in the run state, so the block is busy right after an accept.
  `IRPWD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "accepted back to back")

  // A new result appears only when the decoder has returned to take the next beat.
  `IRPWD_ASSERT(a_result_frees_input, clk, rst_n, !$rose(out_tvalid) || in_tready, "result while busy")

  // An input beat that is waiting keeps its samples.
  `IRPWD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_tvalid && !in_tready, $stable(in_tdata), "in beat changed")

endmodule

bind ir_pulse_width_byte_decoder_core irpwd_checker #(
  .IN_TDATA_W (IN_TDATA_W)
) u_irpwd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

@@ sim/ir_pulse_width_byte_decoder_core_tb.sv @@
// Self-checking testbench for the IR pulse width byte decoder core.

// The bench streams beats of eight line samples into the decoder and checks every
// output beat against a line decoder model kept here. Each input beat yields exactly
// one output beat. So the expected results are a plain FIFO. A row is pushed when an
// input beat is accepted, and the oldest row is popped when an output beat is accepted.
//
// The run has three parts:
//   - A short directed table. It covers reset behavior, a hand-built byte under fast
//     thresholds, a low window with no low sample, the zero thresholds and a write to
//     the unused register index.
//   - Random phases. Each phase has its own register settings and its own idle pattern.
//     Most of the stimulus is well-formed frames: an idle high run, a low header, then
//     data bits with random low widths. Broken bits and random noise beats are mixed in.
//   - A short tail with the resync threshold at the counter maximum, where a long high
//     run never leaves resync.
module ir_pulse_width_byte_decoder_core_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_BEATS = 150;
  localparam logic [15:0] WINDOW_TICKS = 16'd8;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // Phases of the line decoder.
  typedef enum logic [1:0] {
    LINE_RESYNC,
    LINE_HEADER,
    LINE_HIGH,
    LINE_LOW
  } line_phase_t;

  // One output beat as the decoder should present it.
  typedef struct packed {
    logic                         byte_ready;
    logic [irpwd_pkg::DATA_W-1:0] data;
    logic                         frame_err;
  } ir_result_t;

  localparam ir_result_t RES_NONE = '{byte_ready: 1'b0, data: 8'h00, frame_err: 1'b0};
  localparam ir_result_t RES_FERR = '{byte_ready: 1'b0, data: 8'h00, frame_err: 1'b1};

  // A directed row is either a register write or a sample beat. A beat row can pin
  // its expected result when the result is obvious. Otherwise the model supplies it.
  typedef struct {
    bit                  is_cfg;
    irpwd_pkg::cfg_idx_t idx;
    logic [15:0]         val;
    logic [7:0]          smp;
    bit                  pinned;
    ir_result_t          res;
  } dir_row_t;

  typedef struct {
    logic [15:0] resync;
    logic [15:0] header;
    logic [15:0] one_bit;
    int          gap_pct;
    int          stall_pct;
    bit          long_hold;
    bit          mid_pause;
  } run_phase_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [irpwd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [irpwd_pkg::REG_W-1:0]     cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata = 8'h00;   // sample_byte
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [irpwd_pkg::DATA_W-1:0]    out_tdata;          // data_byte
  logic [1:0]                      out_tuser;          // byte_ready, frame_error

  ir_pulse_width_byte_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // The model copy of the registers and the decoder state. Both start at their reset values.
  logic [15:0] thr_resync = 16'd40;
  logic [15:0] thr_header = 16'd8;
  logic [15:0] thr_one    = 16'd5;
  line_phase_t ln_phase   = LINE_RESYNC;
  logic [15:0] ln_ticks   = '0;
  logic [15:0] ln_lows    = '0;
  logic [7:0]  ln_shift   = '0;
  logic [2:0]  ln_bitno   = '0;

  ir_result_t pending_decodes[$];
  bit         line_bits[$];

  int in_gap_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int stall_left = 0;
  int beats_sent = 0;
  int bytes_seen = 0;
  int errs_seen = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  // The directed table. The first rows run at the reset thresholds. The fast
  // thresholds that follow let one byte fit in sixteen beats: a high beat plus one
  // beat of low samples per bit. Low runs of 3, 6, 7, 5, 4, 1, 2 and 7 samples
  // decode against a one-bit threshold of 5.
  dir_row_t dir_rows [0:28] = '{
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'h00, 1, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'hFF, 1, RES_NONE},
    '{1, irpwd_pkg::CFG_RESYNC_HIGH, 16'd0,    8'h00, 0, RES_NONE},
    '{1, irpwd_pkg::CFG_HEADER_LOW,  16'd1,    8'h00, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'h80, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'hFF, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'h1F, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'hFF, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'h03, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'hFF, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'h01, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'hFF, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'h07, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'hFF, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'h0F, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'hFF, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'h7F, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'hFF, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'h3F, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'hFF, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'h01, 0, RES_NONE},
    // A full high window, then a low window made only of high samples.
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'hFF, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'hFF, 1, RES_FERR},
    // Zero thresholds. The write to the unused index must change nothing.
    '{1, irpwd_pkg::CFG_ONE_BIT_LOW, 16'd0,    8'h00, 0, RES_NONE},
    '{1, irpwd_pkg::CFG_UNUSED,      16'hFFFF, 8'h00, 0, RES_NONE},
    '{1, irpwd_pkg::CFG_HEADER_LOW,  16'd0,    8'h00, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'h80, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'hFF, 0, RES_NONE},
    '{0, irpwd_pkg::CFG_UNUSED,      16'h0000, 8'h7F, 0, RES_NONE}
  };

  run_phase_t run_phases [0:5] = '{
    '{16'd40, 16'd8, 16'd5,    0,  0,  0, 0},
    '{16'd3,  16'd2, 16'd3,    47, 0,  0, 1},
    '{16'd0,  16'd1, 16'd1,    0,  47, 1, 0},
    '{16'd12, 16'd5, 16'd7,    25, 25, 0, 0},
    '{16'd20, 16'd3, 16'hFFFF, 25, 25, 0, 0},
    '{16'd1,  16'd1, 16'd0,    0,  0,  0, 0}
  };

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic void line_restart();
    ln_phase = LINE_RESYNC;
    ln_ticks = '0;
    ln_lows  = '0;
    ln_shift = '0;
    ln_bitno = '0;
  endfunction

  // Steps the model decoder through one beat, oldest sample first. A frame error ends
  // the beat, and the samples left in it are dropped.
  function automatic ir_result_t decode_samples(input logic [7:0] smp);
    ir_result_t r;
    logic       s;
    bit         stop;
    r = RES_NONE;
    stop = 1'b0;
    for (int i = 7; i >= 0 && !stop; i--) begin
      s = smp[i];
      ln_ticks = sat16(ln_ticks);
      case (ln_phase)
        LINE_RESYNC: begin
          if (!s) begin
            line_restart();
          end else if (ln_ticks > thr_resync) begin
            ln_phase = LINE_HEADER;
          end
        end
        LINE_HEADER: begin
          if (!s) begin
            ln_lows = sat16(ln_lows);
            if (ln_lows >= thr_header) begin
              ln_phase = LINE_HIGH;
              ln_ticks = '0;
              ln_lows  = '0;
            end
          end
        end
        LINE_HIGH: begin
          // The high window is timed from its first high sample.
          if (s) begin
            if (ln_lows == '0) ln_ticks = 16'd1;
            ln_lows = sat16(ln_lows);
          end
          if (ln_ticks >= WINDOW_TICKS) begin
            ln_phase = LINE_LOW;
            ln_ticks = '0;
            ln_lows  = '0;
          end
        end
        default: begin
          if (!s) begin
            if (ln_lows == '0) ln_ticks = 16'd1;
            ln_lows = sat16(ln_lows);
          end
          if (ln_ticks >= WINDOW_TICKS && ln_lows == '0) begin
            line_restart();
            r.frame_err = 1'b1;
            stop = 1'b1;
          end else if (ln_ticks >= WINDOW_TICKS && s) begin
            ln_shift = {ln_shift[6:0], (ln_lows >= thr_one)};
            ln_phase = LINE_HIGH;
            ln_lows  = '0;
            ln_ticks = '0;
            if (ln_bitno == 3'd7) begin
              ln_bitno = '0;
              r.byte_ready = 1'b1;
              r.data = ln_shift;
            end else begin
              ln_bitno = ln_bitno + 3'd1;
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  // Offers one beat. in_tvalid stays high into the next call unless a gap is taken.
  // This way it is never lowered and raised again in the same time step.
  task automatic send_beat(input logic [7:0] smp, input bit pinned = 1'b0,
                           input ir_result_t pinned_res = RES_NONE);
    ir_result_t predicted;
    if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    do @(posedge clk); while (!in_tready);
    predicted = decode_samples(smp);
    pending_decodes.push_back(pinned ? pinned_res : predicted);
    beats_sent++;
  endtask

  // Stops offering beats and waits until every expected result has been taken.
  task automatic settle_results();
    in_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The trailing idle cycle keeps two writes in a row from touching cfg_we in one step.
  task automatic write_reg(input irpwd_pkg::cfg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      irpwd_pkg::CFG_RESYNC_HIGH: thr_resync = val;
      irpwd_pkg::CFG_HEADER_LOW:  thr_header = val;
      irpwd_pkg::CFG_ONE_BIT_LOW: thr_one = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic void push_run(input bit lvl, input int n);
    for (int k = 0; k < n; k++) line_bits.push_back(lvl);
  endfunction

  task automatic ship_bits();
    logic [7:0] smp;
    while (line_bits.size() >= 8) begin
      for (int k = 7; k >= 0; k--) smp[k] = line_bits.pop_front();
      send_beat(smp);
    end
  endtask

  // Builds one frame on the sample line and ships the whole beats it fills. A
  // previous frame usually ends with a frame error, and that error drops the rest of
  // its beat. So the idle run is made long enough to resync after the lost samples.
  task automatic send_frame();
    int nbits;
    int lows;
    int bit_val;
    nbits = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 8;
    push_run(1'b1, int'(thr_resync) + 25 + $urandom_range(0, 8));
    push_run(1'b0, (thr_header == 16'd0 ? 1 : int'(thr_header)) + $urandom_range(0, 2));
    for (int b = 0; b < nbits; b++) begin
      push_run(1'b1, 8 + $urandom_range(0, 1));
      if ($urandom_range(0, 29) == 0) begin
        // A broken bit: the low window never sees a low sample.
        push_run(1'b1, 8);
        break;
      end
      bit_val = $urandom_range(0, 1);
      if (thr_one > 16'd12) begin
        lows = $urandom_range(1, 12);
      end else if (bit_val == 1 || thr_one <= 16'd1) begin
        lows = (thr_one == 16'd0 ? 1 : int'(thr_one)) + $urandom_range(0, 3);
      end else begin
        lows = $urandom_range(1, int'(thr_one) - 1);
      end
      push_run(1'b0, lows);
      // The bit closes on the first high sample once eight ticks have passed since its first low.
      push_run(1'b1, (lows >= 8 ? 1 : 8 - lows) + $urandom_range(0, 2));
    end
    push_run(1'b1, $urandom_range(0, 6));
    ship_bits();
  endtask

  // The receiver keeps its own count for the long hold-off that the stimulus asks for.
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      stall_left = 300;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Every accepted output beat is compared with the oldest expected result.
  always @(posedge clk) begin : result_check
    ir_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (out_tuser[0]) bytes_seen++;
      if (out_tuser[1]) errs_seen++;
      if (pending_decodes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("Unexpected output beat: data_byte %h byte_ready %b frame_error %b",
                   out_tdata, out_tuser[0], out_tuser[1]);
      end else begin
        want = pending_decodes.pop_front();
        if (out_tuser[0] !== want.byte_ready || out_tdata !== want.data ||
            out_tuser[1] !== want.frame_err) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("Mismatch: byte_ready %b/%b data_byte %h/%h frame_error %b/%b (exp/act)",
                     want.byte_ready, out_tuser[0], want.data, out_tdata,
                     want.frame_err, out_tuser[1]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, pending_decodes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int start;
    bit paused;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        settle_results();
        write_reg(dir_rows[r].idx, dir_rows[r].val);
      end else begin
        send_beat(dir_rows[r].smp, dir_rows[r].pinned, dir_rows[r].res);
      end
    end

    // Random phases. Each one starts from an idle block with fresh thresholds.
    foreach (run_phases[p]) begin
      settle_results();
      write_reg(irpwd_pkg::CFG_RESYNC_HIGH, run_phases[p].resync);
      write_reg(irpwd_pkg::CFG_HEADER_LOW, run_phases[p].header);
      write_reg(irpwd_pkg::CFG_ONE_BIT_LOW, run_phases[p].one_bit);
      in_gap_pct = run_phases[p].gap_pct;
      stall_pct = run_phases[p].stall_pct;
      // During the long hold-off the sender keeps offering beats. The output register
      // fills up and the block has to stall its input.
      if (run_phases[p].long_hold) hold_requests++;
      start = beats_sent;
      paused = 1'b0;
      while (beats_sent - start < PHASE_BEATS) begin
        if (run_phases[p].mid_pause && !paused && beats_sent - start >= PHASE_BEATS / 2) begin
          settle_results();
          paused = 1'b1;
        end
        if ($urandom_range(0, 6) == 0) send_beat(8'($urandom_range(0, 255)));
        else send_frame();
      end
    end

    // With the resync threshold at the counter maximum, a long high run never
    // reaches the header, so nothing decodes from the random beats that follow it.
    settle_results();
    in_gap_pct = 0;
    stall_pct = 0;
    write_reg(irpwd_pkg::CFG_HEADER_LOW, 16'd1);
    write_reg(irpwd_pkg::CFG_RESYNC_HIGH, 16'hFFFF);
    send_beat(8'h00);
    repeat (24) send_beat(8'hFF);
    repeat (20) send_beat(8'($urandom_range(0, 255)));

    settle_results();
    repeat (30) @(posedge clk);

    $display("Ran %0d beats: directed rows, %0d random phases with gaps, stalls and a long hold-off,",
             beats_sent, $size(run_phases));
    $display("and an out-of-reach resync threshold; %0d bytes and %0d frame errors decoded.",
             bytes_seen, errs_seen);
    if (mismatch_cnt == 0 && pending_decodes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_cnt, pending_decodes.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/irpwd_pkg.sv
rtl/irpwd_ctrl.sv
rtl/irpwd_dpath.sv
rtl/ir_pulse_width_byte_decoder_core.sv
rtl/irpwd_checker.sv
sim/ir_pulse_width_byte_decoder_core_tb.sv
